// ===== sv/clt_pkg.sv =====
// ----------------------------------------------------------------------------
// Client lease table package
// Shared types, constants and a helper function for the lease table.
// ----------------------------------------------------------------------------
package clt_pkg;

	localparam int unsigned HASH_W = 32;
	localparam int unsigned TIME_W = 32;
	localparam int unsigned DUR_W  = 31;

	// Lease lifetime after reset, in milliseconds.
	localparam logic [DUR_W-1:0] DUR_RESET = 31'd12000;

	// Request type codes.
	localparam logic REQ_SET   = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_TAKE,
		ST_EMIT
	} clt_state_t;

	typedef struct packed {
		logic              req_type;
		logic [HASH_W-1:0] client_id;
		logic              view_on;
		logic [TIME_W-1:0] now_ms;
	} clt_in_t;

	typedef struct packed {
		logic ack_active;
		logic any_live;
	} clt_out_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic start;
		logic scan;
		logic take;
		logic load_out;
	} clt_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic scan_done;
	} clt_sts_t;

	// True when a - b, read as a signed value, is negative.
	function automatic logic wrap_before(logic [TIME_W-1:0] a, logic [TIME_W-1:0] b);
		logic [TIME_W-1:0] diff;
		diff = a - b;
		return diff[TIME_W-1];
	endfunction

endpackage

// ===== sv/clt_ctrl.sv =====
// ----------------------------------------------------------------------------
// Client lease table controller
// Sequences accept, slot scan, lease take and result hand-off.
// ----------------------------------------------------------------------------
module clt_ctrl
	import clt_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	output logic     out_valid,
	input  logic     out_stall,
	input  clt_sts_t sts,
	output clt_cmd_t cmd
);

	clt_state_t state_q;
	clt_state_t state_d;
	logic       out_valid_q;
	logic       out_free;

	// The output register can take a new beat when empty or being drained.
	assign out_free = !out_valid_q || !out_stall;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (sts.scan_done) state_d = ST_TAKE;
			end
			ST_TAKE: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Commands and handshake outputs.
	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall  = 1'b0;
				cmd.start = in_valid;
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
			end
			ST_TAKE: begin
				cmd.take = 1'b1;
			end
			ST_EMIT: begin
				cmd.load_out = out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Output valid flag: set on load, cleared when the beat is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	// A waiting result is never overwritten.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |-> !cmd.load_out)
		else $error("result overwritten while stalled");

	// An accepted beat always starts a scan.
	a_accept_scans: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == ST_SCAN))
		else $error("accepted beat did not start a scan");

	// A new result appears only after a load command.
	a_valid_from_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(cmd.load_out))
		else $error("output valid rose without a load");

endmodule

// ===== sv/clt_dp.sv =====
// ----------------------------------------------------------------------------
// Client lease table datapath
// Slot memory with valid bits, scan evaluation, lease take and result register.
// ----------------------------------------------------------------------------
module clt_dp
	import clt_pkg::*;
#(
	parameter int unsigned LEASE_SLOTS = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [DUR_W-1:0] cfg_wdata,
	input  clt_in_t          in_data,
	input  clt_cmd_t         cmd,
	output clt_sts_t         sts,
	output clt_out_t         out_data
);

	localparam int unsigned IDX_W = (LEASE_SLOTS > 1) ? $clog2(LEASE_SLOTS) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LEASE_SLOTS - 1);
	localparam int unsigned ENT_W = HASH_W + TIME_W;

	// Configuration and captured request.
	logic [DUR_W-1:0]  dur_q;
	logic              req_q;
	logic [HASH_W-1:0] hash_q;
	logic              on_q;
	logic [TIME_W-1:0] now_q;

	// Slot store: one entry per lease, valid bits cleared by reset.
	logic [ENT_W-1:0]       mem [LEASE_SLOTS];
	logic [LEASE_SLOTS-1:0] vld_q;

	// Scan pipeline: read stage and evaluate stage.
	logic              rd_act_q;
	logic [IDX_W-1:0]  rd_idx_q;
	logic              ev_vld_s1;
	logic [IDX_W-1:0]  ev_idx_s1;
	logic [HASH_W-1:0] rd_hash_s1;
	logic [TIME_W-1:0] rd_exp_s1;

	// Scan results.
	logic              have_free_q;
	logic [IDX_W-1:0]  free_idx_q;
	logic              have_old_q;
	logic [IDX_W-1:0]  old_idx_q;
	logic [TIME_W-1:0] old_exp_q;
	logic              live_q;
	logic              matched_q;

	clt_out_t          out_q;

	logic              is_query;
	logic [TIME_W-1:0] new_exp;
	logic              ev_en;
	logic              slot_used;
	logic              slot_expired;
	logic              match_now;
	logic              clear_now;
	logic              free_now;
	logic              old_now;
	logic              live_now;
	logic              refresh_now;
	logic              take_now;
	logic              mem_we;
	logic [IDX_W-1:0]  mem_waddr;

	// Evaluation of the slot that was read in the previous cycle.
	always_comb begin
		is_query     = (req_q == REQ_QUERY);
		new_exp      = now_q + TIME_W'(dur_q);
		ev_en        = cmd.scan && ev_vld_s1;
		slot_used    = (rd_hash_s1 != '0);
		slot_expired = !wrap_before(now_q, rd_exp_s1);
		match_now    = ev_en && !is_query && (rd_hash_s1 == hash_q);
		clear_now    = (ev_en && !match_now && slot_used && slot_expired) ||
		               (match_now && !on_q);
		free_now     = ev_en && !is_query && !match_now && (!slot_used || slot_expired);
		old_now      = ev_en && !is_query && !match_now && slot_used && !slot_expired &&
		               (!have_old_q || wrap_before(rd_exp_s1, old_exp_q));
		live_now     = ev_en && is_query && slot_used && !slot_expired;
		refresh_now  = match_now && on_q;
		take_now     = cmd.take && !is_query && !matched_q && on_q &&
		               (have_free_q || have_old_q);
		mem_we       = refresh_now || take_now;
		mem_waddr    = take_now ? (have_free_q ? free_idx_q : old_idx_q) : ev_idx_s1;
		sts.scan_done = ev_en && ((ev_idx_s1 == LAST_IDX) || match_now);
	end

	// Lease duration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dur_q <= DUR_RESET;
		end else if (cfg_we) begin
			dur_q <= cfg_wdata;
		end
	end

	// Request capture; a zero hash stands for client 1.
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			req_q  <= in_data.req_type;
			hash_q <= (in_data.client_id == '0) ? HASH_W'(1) : in_data.client_id;
			on_q   <= in_data.view_on;
			now_q  <= in_data.now_ms;
		end
	end

	// Slot memory write and registered read; an invalid entry reads as zero.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= {hash_q, new_exp};
		end
		if (cmd.scan && rd_act_q) begin
			if (vld_q[rd_idx_q]) begin
				{rd_hash_s1, rd_exp_s1} <= mem[rd_idx_q];
			end else begin
				rd_hash_s1 <= '0;
				rd_exp_s1  <= '0;
			end
		end
	end

	// Valid bits: set on write, cleared when a slot is released or expires.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (mem_we) begin
			vld_q[mem_waddr] <= 1'b1;
		end else if (clear_now) begin
			vld_q[ev_idx_s1] <= 1'b0;
		end
	end

	// Scan control: read address walk and evaluate-stage valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_act_q    <= 1'b0;
			rd_idx_q    <= '0;
			ev_vld_s1   <= 1'b0;
			ev_idx_s1   <= '0;
			have_free_q <= 1'b0;
			have_old_q  <= 1'b0;
			live_q      <= 1'b0;
			matched_q   <= 1'b0;
		end else if (cmd.start) begin
			rd_act_q    <= 1'b1;
			rd_idx_q    <= '0;
			ev_vld_s1   <= 1'b0;
			have_free_q <= 1'b0;
			have_old_q  <= 1'b0;
			live_q      <= 1'b0;
			matched_q   <= 1'b0;
		end else if (cmd.scan) begin
			ev_vld_s1 <= rd_act_q && !match_now;
			ev_idx_s1 <= rd_idx_q;
			if (match_now || (rd_idx_q == LAST_IDX)) begin
				rd_act_q <= 1'b0;
			end else if (rd_act_q) begin
				rd_idx_q <= rd_idx_q + 1'b1;
			end
			if (match_now) matched_q <= 1'b1;
			if (free_now && !have_free_q) have_free_q <= 1'b1;
			if (old_now) have_old_q <= 1'b1;
			if (live_now) live_q <= 1'b1;
		end
	end

	// Noted free slot and oldest live slot.
	always_ff @(posedge clk) begin
		if (free_now && !have_free_q) begin
			free_idx_q <= ev_idx_s1;
		end
		if (old_now) begin
			old_idx_q <= ev_idx_s1;
			old_exp_q <= rd_exp_s1;
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_q.ack_active <= !is_query && on_q;
			out_q.any_live   <= is_query && live_q;
		end
	end

	assign out_data = out_q;

endmodule

// ===== sv/client_lease_table.sv =====
// ----------------------------------------------------------------------------
// Client lease table
// Fixed table of client leases with wrap-around expiry, set and query requests.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid, in_stall, in_data) carries one request per beat:
//   a set or release of a client lease, or a query that sweeps expired leases.
//   Output channel (out_valid, out_stall, out_data) returns exactly one result
//   beat per request, in request order.
//   cfg_we/cfg_wdata write the lease duration; write it only while idle.
// Sequencing:
//   A request walks the slot memory one slot per cycle through a registered
//   read, ending early on a hash match, then passes through the lease take
//   and loads the result. A new request is accepted only once the previous
//   one has loaded its result into the output register.
// Reset:
//   arst_n clears every slot valid bit, so all leases read as empty, and sets
//   the lease duration to 12000 ms. No clearing pass is needed.
// Stall:
//   The result sits in an output register; the next request is accepted while
//   it waits, and that request's result holds until the register drains.
// ----------------------------------------------------------------------------
module client_lease_table
	import clt_pkg::*;
#(
	parameter int unsigned LEASE_SLOTS = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [DUR_W-1:0] cfg_wdata,
	input  logic             in_valid,
	output logic             in_stall,
	input  clt_in_t          in_data,
	output logic             out_valid,
	input  logic             out_stall,
	output clt_out_t         out_data
);

	clt_cmd_t cmd;
	clt_sts_t sts;

	// Sequencing of each request.
	clt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Slot store and scan evaluation.
	clt_dp #(
		.LEASE_SLOTS (LEASE_SLOTS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_data   (in_data),
		.cmd       (cmd),
		.sts       (sts),
		.out_data  (out_data)
	);

endmodule
